FILE: design/windowed_top_k_frequency_assert.svh
// Assertion macros for the windowed top-k frequency block.
// Included by the top level only; no other dependencies.
`ifndef WINDOWED_TOP_K_FREQUENCY_ASSERT_SVH
`define WINDOWED_TOP_K_FREQUENCY_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define WTK_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication checked on every clock edge outside reset.
`define WTK_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

FILE: design/wtkf_pkg.sv
// Shared types and constants for the windowed top-k frequency block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wtkf_pkg;
    localparam logic CFG_WINDOW_START = 1'b0;
    localparam logic CFG_WINDOW_END   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RANK_RD,
        ST_RANK_SH,
        ST_EMIT,
        ST_CLEAR
    } t_state;

    // Shift-chain command from controller to cells
    typedef struct packed {
        logic        load;
        logic        clear;
        logic [31:0] id;
        logic [31:0] cnt;
    } t_cell_cmd;
endpackage
`default_nettype wire

FILE: design/wtkf_cell.sv
// One rank cell: holds one id/count pair of the running top-k list.
// Depends on wtkf_pkg for the command struct.
`timescale 1ns / 1ps
`default_nettype none
module wtkf_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire wtkf_pkg::t_cell_cmd i_cmd,
    input  wire                  i_prev_ins,
    input  wire [31:0]           i_prev_id,
    input  wire [31:0]           i_prev_cnt,
    output logic                 o_ins,
    output logic [31:0]          o_id,
    output logic [31:0]          o_cnt
);
    logic [31:0] r_id, n_id;
    logic [31:0] r_cnt, n_cnt;
    logic        w_take;

    // Insert here when candidate beats this cell and no earlier cell took it
    assign w_take = i_cmd.load && (i_cmd.cnt > r_cnt) && !i_prev_ins;
    assign o_ins  = i_prev_ins || w_take;
    assign o_id   = r_id;
    assign o_cnt  = r_cnt;

    // Pick next value: clear, shift from neighbor, take candidate, or hold
    always_comb begin
        n_id  = r_id;
        n_cnt = r_cnt;
        if (i_cmd.clear) begin
            n_id  = '0;
            n_cnt = '0;
        end else if (i_cmd.load && i_prev_ins) begin
            n_id  = i_prev_id;
            n_cnt = i_prev_cnt;
        end else if (w_take) begin
            n_id  = i_cmd.id;
            n_cnt = i_cmd.cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id  <= '0;
            r_cnt <= '0;
        end else begin
            r_id  <= n_id;
            r_cnt <= n_cnt;
        end
    end
endmodule
`default_nettype wire

FILE: design/wtkf_rank_chain.sv
// Row of TOP_K rank cells forming a sorted insertion chain.
// Depends on wtkf_pkg and wtkf_cell.
`timescale 1ns / 1ps
`default_nettype none
module wtkf_rank_chain #(
    parameter int TOP_K = 10
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire wtkf_pkg::t_cell_cmd    i_cmd,
    input  wire [$clog2(TOP_K+1)-1:0]   i_sel,
    output logic [31:0]                 o_id,
    output logic [31:0]                 o_cnt
);
    logic [TOP_K:0]    w_ins;
    logic [31:0]       w_id  [TOP_K+1];
    logic [31:0]       w_cnt [TOP_K+1];

    assign w_ins[0] = 1'b0;
    assign w_id[0]  = '0;
    assign w_cnt[0] = '0;

    // Chain cells: each hands its pair to the next on insert
    for (genvar g = 0; g < TOP_K; g++) begin : g_cell
        wtkf_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (i_cmd),
            .i_prev_ins (w_ins[g]),
            .i_prev_id  (w_id[g]),
            .i_prev_cnt (w_cnt[g]),
            .o_ins      (w_ins[g+1]),
            .o_id       (w_id[g+1]),
            .o_cnt      (w_cnt[g+1])
        );
    end

    // Read out selected rank (index 0 reads as empty)
    assign o_id  = w_id[i_sel];
    assign o_cnt = w_cnt[i_sel];
endmodule
`default_nettype wire

FILE: design/windowed_top_k_frequency.sv
// Windowed top-k frequency counter: window filter, id/count table, rank chain.
// An out-of-window record that is not last leaves busy low; an in-window record holds
// busy while the table is scanned for its id, and a new id is appended when the table
// has room. A last record then ranks each used entry through the chain (read, then
// shift), emits one result per cycle, and clears the table. Results cannot be stalled.
// Synchronous active-low reset clears control state, window registers and rank cells.
`timescale 1ns / 1ps
`default_nettype none
`include "windowed_top_k_frequency_assert.svh"
module windowed_top_k_frequency #(
    parameter int DISTINCT_IDS = 1024,
    parameter int TOP_K        = 10
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [63:0] i_timestamp,
    input  wire  [31:0] i_resource_id,
    input  wire         i_end_of_log,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [0:0]  i_cfg_index,
    input  wire  [63:0] i_cfg_data,
    output logic        o_valid,
    output logic [5:0]  o_rank,
    output logic [31:0] o_top_id,
    output logic [31:0] o_access_count,
    output logic        o_table_overflow,
    output logic        o_last_result
);
    localparam int AW = $clog2(DISTINCT_IDS);
    localparam int UW = $clog2(DISTINCT_IDS + 1);
    localparam int KW = $clog2(TOP_K + 1);

    wtkf_pkg::t_state r_state, n_state;
    logic [63:0]  r_wstart, r_wend;
    logic [31:0]  r_id;
    logic         r_last;
    logic [UW-1:0] r_used, n_used;
    logic         r_ovf, n_ovf;
    logic [UW-1:0] r_ptr, n_ptr;
    logic [KW-1:0] r_sel, n_sel;
    logic [31:0]  r_id_mem  [DISTINCT_IDS];
    logic [31:0]  r_cnt_mem [DISTINCT_IDS];
    logic [31:0]  r_rd_id, r_rd_cnt;
    logic         r_rd_ok;
    logic         w_accept, w_inwin, w_hit;
    logic         w_we;
    logic [AW-1:0] w_waddr;
    logic [31:0]  w_wid, w_wcnt;
    logic [AW-1:0] w_raddr;
    wtkf_pkg::t_cell_cmd w_cmd;
    logic [31:0]  w_sel_id, w_sel_cnt;

    assign busy        = (r_state != wtkf_pkg::ST_IDLE);
    assign w_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign w_inwin = ($signed(r_wstart) <= $signed(i_timestamp)) &&
                     ($signed(i_timestamp) <= $signed(r_wend));
    assign w_raddr = r_ptr[AW-1:0];
    assign w_hit   = r_rd_ok && (r_rd_id == r_id);

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wstart <= '0;
            r_wend   <= 64'h7FFF_FFFF_FFFF_FFFF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == wtkf_pkg::CFG_WINDOW_START) r_wstart <= i_cfg_data;
            else r_wend <= i_cfg_data;
        end
    end

    // Table memories: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_id_mem[w_waddr]  <= w_wid;
            r_cnt_mem[w_waddr] <= w_wcnt;
        end
        r_rd_id  <= r_id_mem[w_raddr];
        r_rd_cnt <= r_cnt_mem[w_raddr];
    end

    // Hold the accepted record
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_id   <= i_resource_id;
            r_last <= i_end_of_log;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wtkf_pkg::ST_IDLE;
            r_used  <= '0;
            r_ovf   <= 1'b0;
            r_ptr   <= '0;
            r_sel   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_ovf   <= n_ovf;
            r_ptr   <= n_ptr;
            r_sel   <= n_sel;
            r_rd_ok <= (n_state == wtkf_pkg::ST_SCAN) && (r_state == wtkf_pkg::ST_SCAN) &&
                       (r_ptr < r_used);
        end
    end

    // Sequencer: scan table, update count or append new id, rank, emit, clear
    always_comb begin
        n_state  = r_state;
        n_used   = r_used;
        n_ovf    = r_ovf;
        n_ptr    = r_ptr;
        n_sel    = r_sel;
        w_we     = 1'b0;
        w_waddr  = r_ptr[AW-1:0] - AW'(1);
        w_wid    = r_id;
        w_wcnt   = (r_rd_cnt == 32'hFFFF_FFFF) ? r_rd_cnt : r_rd_cnt + 32'd1;
        w_cmd    = '{load: 1'b0, clear: 1'b0, id: r_rd_id, cnt: r_rd_cnt};
        o_valid  = 1'b0;
        o_rank   = '0;
        o_top_id = '0;
        o_access_count   = '0;
        o_table_overflow = r_ovf;
        o_last_result    = 1'b0;
        case (r_state)
            wtkf_pkg::ST_IDLE: begin
                n_ptr = '0;
                if (w_accept) begin
                    if (w_inwin) n_state = wtkf_pkg::ST_SCAN;
                    else if (i_end_of_log) n_state = wtkf_pkg::ST_RANK_RD;
                end
            end
            wtkf_pkg::ST_SCAN: begin
                // r_ptr leads the registered read by one entry
                if (w_hit) begin
                    w_we    = 1'b1;
                    n_ptr   = '0;
                    n_state = r_last ? wtkf_pkg::ST_RANK_RD : wtkf_pkg::ST_IDLE;
                end else if (r_ptr > r_used || (r_ptr == r_used && r_ptr != '0 &&
                             !r_rd_ok) || r_used == '0 ||
                             (r_ptr == r_used && r_rd_ok == 1'b0)) begin
                    if (r_used < UW'(DISTINCT_IDS)) begin
                        w_we    = 1'b1;
                        w_waddr = r_used[AW-1:0];
                        w_wcnt  = 32'd1;
                        n_used  = r_used + UW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_ptr   = '0;
                    n_state = r_last ? wtkf_pkg::ST_RANK_RD : wtkf_pkg::ST_IDLE;
                end else begin
                    n_ptr = r_ptr + UW'(1);
                end
            end
            wtkf_pkg::ST_RANK_RD: begin
                // Issue read of entry r_ptr
                if (r_ptr >= r_used) begin
                    n_sel   = KW'(1);
                    n_state = wtkf_pkg::ST_EMIT;
                end else begin
                    n_state = wtkf_pkg::ST_RANK_SH;
                end
            end
            wtkf_pkg::ST_RANK_SH: begin
                w_cmd.load = 1'b1;
                n_ptr   = r_ptr + UW'(1);
                n_state = wtkf_pkg::ST_RANK_RD;
            end
            wtkf_pkg::ST_EMIT: begin
                o_valid        = 1'b1;
                o_rank         = (w_sel_cnt == '0) ? 6'd0 : 6'(r_sel);
                o_top_id       = w_sel_id;
                o_access_count = w_sel_cnt;
                // Every table entry holds a nonzero count, so ranks run out at r_used
                if (w_sel_cnt == '0 || r_sel == KW'(TOP_K) || UW'(r_sel) >= r_used) begin
                    o_last_result = 1'b1;
                    n_state = wtkf_pkg::ST_CLEAR;
                end else begin
                    n_sel = r_sel + KW'(1);
                end
            end
            wtkf_pkg::ST_CLEAR: begin
                w_cmd.clear = 1'b1;
                n_used  = '0;
                n_ovf   = 1'b0;
                n_ptr   = '0;
                n_sel   = '0;
                n_state = wtkf_pkg::ST_IDLE;
            end
            default: n_state = wtkf_pkg::ST_IDLE;
        endcase
    end

    wtkf_rank_chain #(.TOP_K(TOP_K)) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_sel   (r_sel),
        .o_id    (w_sel_id),
        .o_cnt   (w_sel_cnt)
    );

    `WTK_ASSERT_IMPL(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= UW'(DISTINCT_IDS))
    `WTK_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, r_state == wtkf_pkg::ST_CLEAR, r_used == '0 && !r_ovf)
    `WTK_ASSERT_IMPL(a_valid_busy, i_clk, i_rst_n, o_valid, busy)
endmodule
`default_nettype wire

FILE: sim/windowed_top_k_frequency_test.sv
// Self-checking testbench for the windowed top-k frequency block.
// Depends on wtkf_pkg and windowed_top_k_frequency from the design folder.
`timescale 1ns / 1ps
module windowed_top_k_frequency_test;
    localparam int TABLE_DEPTH = 1024;
    localparam int RANK_DEPTH  = 10;
    localparam int IDLE_LIMIT  = 20000;
    localparam logic signed [63:0] TS_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] TS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [5:0]  rank;
        logic [31:0] top_id;
        logic [31:0] access_count;
        logic        table_overflow;
        logic        last_result;
    } t_rank_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [63:0] i_timestamp = '0;
    logic [31:0] i_resource_id = '0;
    logic        i_end_of_log = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [0:0]  i_cfg_index = wtkf_pkg::CFG_WINDOW_START;
    logic [63:0] i_cfg_data = '0;
    wire         busy;
    wire         o_cfg_ready;
    wire         o_valid;
    wire  [5:0]  o_rank;
    wire  [31:0] o_top_id;
    wire  [31:0] o_access_count;
    wire         o_table_overflow;
    wire         o_last_result;

    windowed_top_k_frequency dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_timestamp(i_timestamp), .i_resource_id(i_resource_id),
        .i_end_of_log(i_end_of_log), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_rank(o_rank), .o_top_id(o_top_id),
        .o_access_count(o_access_count), .o_table_overflow(o_table_overflow),
        .o_last_result(o_last_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: window registers and the per-query tally
    logic signed [63:0] win_lo = 64'sd0;
    logic signed [63:0] win_hi = TS_MAX;
    logic [31:0] seen_ids[$];
    logic [31:0] seen_counts[$];
    logic        dropped_any = 1'b0;
    t_rank_item  ranked_q[$];

    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int queries_run = 0;
    int idle_cycles = 0;
    int burst_left = 0;

    // Count one record and, on the last one, rank the table
    task automatic tally_record(input logic [63:0] ts, input logic [31:0] id,
                                input logic last);
        logic [31:0] top_ids[RANK_DEPTH];
        logic [31:0] top_cnts[RANK_DEPTH];
        t_rank_item  r;
        bit          found;
        int          n;
        found = 0;
        if (win_lo <= $signed(ts) && $signed(ts) <= win_hi) begin
            foreach (seen_ids[i]) begin
                if (!found && seen_ids[i] == id) begin
                    found = 1;
                    if (seen_counts[i] != 32'hFFFF_FFFF) seen_counts[i]++;
                end
            end
            if (!found) begin
                if (seen_ids.size() < TABLE_DEPTH) begin
                    seen_ids.push_back(id);
                    seen_counts.push_back(32'd1);
                end else begin
                    dropped_any = 1'b1;
                end
            end
        end
        if (!last) return;
        for (int k = 0; k < RANK_DEPTH; k++) begin
            top_ids[k] = '0;
            top_cnts[k] = '0;
        end
        // Insert behind every entry with an equal or larger count
        foreach (seen_ids[i]) begin
            found = 0;
            for (int p = 0; p < RANK_DEPTH && !found; p++) begin
                if (seen_counts[i] > top_cnts[p]) begin
                    for (int s = RANK_DEPTH - 1; s > p; s--) begin
                        top_ids[s] = top_ids[s-1];
                        top_cnts[s] = top_cnts[s-1];
                    end
                    top_ids[p] = seen_ids[i];
                    top_cnts[p] = seen_counts[i];
                    found = 1;
                end
            end
        end
        n = 0;
        while (n < RANK_DEPTH && top_cnts[n] != 0) n++;
        for (int k = 0; k < (n == 0 ? 1 : n); k++) begin
            r.rank = (n == 0) ? 6'd0 : 6'(k + 1);
            r.top_id = top_ids[k];
            r.access_count = top_cnts[k];
            r.table_overflow = dropped_any;
            r.last_result = (k == (n == 0 ? 0 : n - 1));
            ranked_q.push_back(r);
        end
        seen_ids.delete();
        seen_counts.delete();
        dropped_any = 1'b0;
        queries_run++;
    endtask

    // Send one record; start stays high so back-to-back items need no re-raise
    task automatic send_record(input logic [63:0] ts, input logic [31:0] id,
                               input logic last);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        i_timestamp <= ts;
        i_resource_id <= id;
        i_end_of_log <= last;
        do @(posedge i_clk); while (busy);
        tally_record(ts, id, last);
        items_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Hold off until every result is in and the last scan has finished
    task automatic wait_drained;
        start <= 1'b0;
        while (ranked_q.size() != 0) @(posedge i_clk);
        repeat (seen_ids.size() + 8) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [0:0] idx, input logic [63:0] val);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == wtkf_pkg::CFG_WINDOW_START) win_lo = val;
        else win_hi = val;
    endtask

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (ranked_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result rank=%0d id=%h count=%0d",
                             o_rank, o_top_id, o_access_count);
            end else begin
                t_rank_item e;
                e = ranked_q.pop_front();
                if (o_rank !== e.rank || o_top_id !== e.top_id ||
                    o_access_count !== e.access_count ||
                    o_table_overflow !== e.table_overflow ||
                    o_last_result !== e.last_result) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch exp rank=%0d id=%h cnt=%0d ovf=%b last=%b",
                                  " got rank=%0d id=%h cnt=%0d ovf=%b last=%b"},
                                 e.rank, e.top_id, e.access_count, e.table_overflow,
                                 e.last_result, o_rank, o_top_id, o_access_count,
                                 o_table_overflow, o_last_result);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake of any kind
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d results outstanding", ranked_q.size());
            $display("FAIL windowed_top_k_frequency");
            $finish;
        end
    end

    // Reset window, edges of the default window and a query with no hits
    task automatic test_default_window;
        send_record(64'd0, 32'h0000_0000, 1'b0);
        send_record(TS_MAX, 32'hFFFF_FFFF, 1'b0);
        send_record(64'hFFFF_FFFF_FFFF_FFFF, 32'h1234_5678, 1'b0);
        send_record(TS_MIN, 32'h1234_5678, 1'b0);
        send_record(64'd5, 32'hFFFF_FFFF, 1'b1);
        send_record(TS_MIN, 32'hAAAA_5555, 1'b1);
    endtask

    // Window extremes, a single-point window and an empty window
    task automatic test_window_extremes;
        write_window(wtkf_pkg::CFG_WINDOW_START, TS_MIN);
        write_window(wtkf_pkg::CFG_WINDOW_END, TS_MAX);
        send_record(TS_MIN, 32'h5555_AAAA, 1'b0);
        send_record(TS_MAX, 32'h5555_AAAA, 1'b1);
        write_window(wtkf_pkg::CFG_WINDOW_START, TS_MIN);
        write_window(wtkf_pkg::CFG_WINDOW_END, TS_MIN);
        send_record(TS_MIN, 32'h0000_0001, 1'b0);
        send_record(TS_MIN + 64'sd1, 32'h0000_0002, 1'b1);
        write_window(wtkf_pkg::CFG_WINDOW_START, TS_MAX);
        write_window(wtkf_pkg::CFG_WINDOW_END, TS_MIN);
        send_record(TS_MAX, 32'h0000_0003, 1'b0);
        send_record(TS_MIN, 32'h0000_0004, 1'b1);
        write_window(wtkf_pkg::CFG_WINDOW_START, TS_MAX);
        write_window(wtkf_pkg::CFG_WINDOW_END, TS_MAX);
        send_record(TS_MAX, 32'h8000_0000, 1'b1);
    endtask

    // Twelve ids with tied counts: more ids than ranks, ties by first arrival
    task automatic test_ranking_ties;
        write_window(wtkf_pkg::CFG_WINDOW_START, 64'sd0);
        for (int i = 0; i < 12; i++)
            repeat (1 + (i % 3)) send_record(64'(i), 32'h100 + 32'(i), 1'b0);
        send_record(64'sd1, 32'h100, 1'b1);
    endtask

    // Many distinct ids over the full time range, then a fresh query
    task automatic test_many_ids;
        write_window(wtkf_pkg::CFG_WINDOW_START, TS_MIN);
        for (int i = 0; i < 30; i++)
            send_record({$urandom, $urandom}, 32'h4000_0000 + 32'(i), 1'b0);
        send_record(64'sd7, 32'h4000_0003, 1'b0);
        send_record(64'sd7, 32'h4000_001D, 1'b0);
        send_record(64'sd7, 32'h7777_0001, 1'b1);
        // Next query must start clean
        send_record(64'sd7, 32'h7777_0001, 1'b1);
    endtask

    // Random queries over random windows, mostly small id pools
    task automatic test_random_queries;
        logic [31:0] pool[8];
        logic signed [63:0] base, span;
        logic [63:0] ts;
        int len;
        while (items_sent < 110) begin
            base = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                                 : 64'($signed($urandom_range(0, 2000)) - 1000);
            span = $urandom_range(0, 3) == 0 ? -64'sd1 : 64'($urandom_range(0, 50));
            write_window(wtkf_pkg::CFG_WINDOW_START, base);
            write_window(wtkf_pkg::CFG_WINDOW_END, base + span);
            foreach (pool[i]) pool[i] = ($urandom_range(0, 1) == 0) ? $urandom
                                                                    : 32'($urandom_range(0, 15));
            len = $urandom_range(1, 18);
            for (int j = 0; j < len; j++) begin
                if ($urandom_range(0, 9) == 0) ts = {$urandom, $urandom};
                else ts = base + 64'($signed($urandom_range(0, 56)) - 3);
                send_record(ts, pool[$urandom_range(0, 7)], j == len - 1);
            end
            if ($urandom_range(0, 4) == 0) begin
                pause_sender($urandom_range(1, 4));
                while (ranked_q.size() != 0) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_window();
        test_window_extremes();
        test_ranking_ties();
        test_many_ids();
        test_random_queries();
        wait_drained();
        repeat (50) @(posedge i_clk);
        $display("Ran %0d records in %0d queries, checked %0d ranked results,",
                 items_sent, queries_run, results_seen);
        $display("covering window edges, empty windows, rank ties and more ids than ranks.");
        if (mismatches == 0 && ranked_q.size() == 0) begin
            $display("PASS windowed_top_k_frequency");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, ranked_q.size());
            $display("FAIL windowed_top_k_frequency");
        end
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+design
design/wtkf_pkg.sv
design/wtkf_cell.sv
design/wtkf_rank_chain.sv
design/windowed_top_k_frequency.sv
sim/windowed_top_k_frequency_test.sv
